>>> hw/rtl/csh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the codon skew histogram
package csh_pkg;

  localparam int NUM_CODONS  = 64;
  localparam int NUM_NUC     = 4;
  localparam int CNT_W       = 32;
  localparam int OUT_W       = 32;
  localparam int NUM_CLASSES = 3;
  localparam int NUM_BINS    = NUM_CLASSES * NUM_NUC + 1;
  localparam int TOTAL_BIN   = NUM_CLASSES * NUM_NUC;
  localparam int NUM_CNT     = NUM_BINS * 2;
  localparam int CNT_IDX_W   = $clog2(NUM_CNT);
  localparam int BIN_W       = 4;
  localparam int CODON_W     = 7;
  localparam int CODON_AW    = (NUM_CODONS > 1) ? $clog2(NUM_CODONS) : 1;
  localparam int DELTA_W     = 5;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CLS_NULL     = 2'd0,
    CLS_ENRICHED = 2'd1,
    CLS_DEPLETED = 2'd2,
    CLS_SPARE    = 2'd3
  } sign_class_t;

  // write request into the sign class table
  typedef struct packed {
    logic                en;
    logic [1:0]          nuc;
    logic [CODON_AW-1:0] addr;
    logic [1:0]          cls;
  } tbl_wr_t;

  // read request: all nucleotide rows at one codon address
  typedef struct packed {
    logic                en;
    logic [CODON_AW-1:0] addr;
  } tbl_rd_t;

endpackage

>>> hw/rtl/csh_class_mem.sv
`timescale 1ns / 1ps
// sign class table: one bank per nucleotide, registered read of all banks at once
module csh_class_mem
  import csh_pkg::*;
(
  input  logic                         clk,
  input  tbl_wr_t                      wr,
  input  tbl_rd_t                      rd,
  output logic [NUM_NUC-1:0][1:0]      rd_data
);

  logic [1:0]             mem [NUM_NUC][NUM_CODONS];
  logic [NUM_NUC-1:0][1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.nuc][wr.addr] <= wr.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      for (int n = 0; n < NUM_NUC; n++) begin
        rd_data_r[n] <= mem[n][rd.addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/codon_skew_histogram_top.sv
`timescale 1ns / 1ps
// Codon skew histogram: two-stage update path, one word per unstalled clock.
// Input channel in_*: one operation per word (count a codon cell, load a
// sign class entry, read a counter, clear all counters), accepted when
// in_valid is high and in_stall low. Only a read returns a word, on the
// out_* channel, accepted when out_valid is high and out_stall low.
// cfg_* writes the complement map; cfg_ready is always high. Writes must
// only be made while the block is idle; the block does not enforce it.
// Throughput: one word per cycle while in_stall is low. The class table
// is read into its register as a word is accepted; as stage 1 moves on,
// the counter update is applied or the read value captured into the
// output register, where a read word then shows on out_valid.
// The 26 counters sit in flip-flops, each with its own adder, so all five
// updates of one cell land together and a following cell sees them
// without any hold-off.
// Reset clears the counters, the pipeline valids and sets the complement
// map to 27; the class table is not cleared and must be loaded first.
// When the receiver stalls, a read waiting in the output register holds;
// a further read behind it stalls the input, other operations keep flowing.
module codon_skew_histogram_top
  import csh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic                 in_cell_excluded,
  input  logic                 in_cell_direct,
  input  logic                 in_cell_reverse,
  input  logic [CODON_W-1:0]   in_codon_index,
  input  logic signed [1:0]    in_step_amount,
  input  logic [1:0]           in_table_nucleotide,
  input  logic [1:0]           in_table_class,
  input  logic [BIN_W-1:0]     in_read_bin,
  input  logic                 in_read_strand,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [OUT_W-1:0] out_count_value,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_complement_map
);

  localparam logic [7:0] COMP_MAP_RST = 8'd27;

  logic                    in_accept;
  logic                    codon_ok;
  tbl_wr_t                 tbl_wr;
  tbl_rd_t                 tbl_rd;
  logic [NUM_NUC-1:0][1:0] tbl_cls;

  logic [7:0]              comp_map_r;

  logic                    s1_valid_r;
  op_t                     s1_op_r;
  logic                    s1_skip_r;
  logic                    s1_strand_r;
  logic                    s1_reverse_r;
  logic signed [1:0]       s1_step_r;
  logic [BIN_W-1:0]        s1_read_bin_r;
  logic                    s1_read_strand_r;
  logic                    s1_go;
  logic                    out_free;

  logic [CNT_W-1:0]        cnt_r   [NUM_CNT];
  logic [CNT_W-1:0]        cnt_nxt [NUM_CNT];
  logic signed [DELTA_W-1:0] delta [NUM_CNT];
  logic signed [DELTA_W-1:0] inc;
  logic [BIN_W-1:0]        bin_n   [NUM_NUC];
  logic [1:0]              nuc_b   [NUM_NUC];

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_value_r;
  logic signed [CNT_W-1:0] read_sel;

  // ---------------- front: accept and table access ----------------
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && ((s1_op_r != OP_READ) || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign codon_ok  = in_codon_index < CODON_W'(NUM_CODONS);

  always_comb begin
    tbl_wr.en   = in_accept && (op_t'(in_op) == OP_LOAD) && codon_ok;
    tbl_wr.nuc  = in_table_nucleotide;
    tbl_wr.addr = in_codon_index[CODON_AW-1:0];
    // class code three is stored as depleted
    tbl_wr.cls  = (in_table_class == CLS_SPARE) ? CLS_DEPLETED : in_table_class;
    tbl_rd.en   = in_accept && (op_t'(in_op) == OP_COUNT);
    tbl_rd.addr = in_codon_index[CODON_AW-1:0];
  end

  csh_class_mem u_class_mem (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (tbl_cls)
  );

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_map_r <= COMP_MAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      comp_map_r <= cfg_complement_map;
    end
  end

  // ---------------- stage 1 registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r          <= op_t'(in_op);
      s1_skip_r        <= in_cell_excluded || !codon_ok;
      s1_strand_r      <= !in_cell_direct;
      s1_reverse_r     <= in_cell_reverse;
      s1_step_r        <= in_step_amount;
      s1_read_bin_r    <= in_read_bin;
      s1_read_strand_r <= in_read_strand;
    end
  end

  // ---------------- counter update ----------------
  // zero step means clear then add one
  assign inc = (s1_step_r == 2'sd0) ? DELTA_W'(1) : DELTA_W'(s1_step_r);

  always_comb begin
    for (int n = 0; n < NUM_NUC; n++) begin
      nuc_b[n] = s1_reverse_r ? comp_map_r[2*n +: 2] : 2'(n);
      bin_n[n] = BIN_W'(nuc_b[n]) * BIN_W'(NUM_CLASSES) + BIN_W'(tbl_cls[n]);
    end
  end

  // several nucleotides may land in the same bin, so sum their hits
  always_comb begin
    for (int k = 0; k < NUM_CNT; k++) begin
      delta[k] = '0;
      if (!s1_skip_r && (s1_strand_r == 1'(k % 2))) begin
        for (int n = 0; n < NUM_NUC; n++) begin
          if (bin_n[n] == BIN_W'(k / 2)) begin
            delta[k] = delta[k] + inc;
          end
        end
        if ((k / 2) == TOTAL_BIN) begin
          delta[k] = delta[k] + inc;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CNT; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (s1_go) begin
        unique case (s1_op_r)
          OP_CLEAR: cnt_nxt[k] = '0;
          OP_COUNT: begin
            if (s1_step_r == 2'sd0) begin
              cnt_nxt[k] = CNT_W'(delta[k]);
            end else begin
              cnt_nxt[k] = cnt_r[k] + CNT_W'(delta[k]);
            end
          end
          OP_LOAD,
          OP_READ:  cnt_nxt[k] = cnt_r[k];
          default:  cnt_nxt[k] = cnt_r[k];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_CNT; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // ---------------- read path and output register ----------------
  always_comb begin
    if (s1_read_bin_r < BIN_W'(NUM_BINS)) begin
      read_sel = signed'(cnt_r[CNT_IDX_W'({s1_read_bin_r, s1_read_strand_r})]);
    end else begin
      read_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && (s1_op_r == OP_READ)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_op_r == OP_READ)) begin
      out_value_r <= OUT_W'(read_sel);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_value_r;

  // ---------------- assertions ----------------
  a_read_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_op_r == OP_READ) |=> out_valid_r)
    else $error("read word did not reach the output register");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty update stage");

  a_clear_empties_total: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_op_r == OP_CLEAR) |=> (cnt_r[2*TOTAL_BIN] == '0)
                                       && (cnt_r[2*TOTAL_BIN+1] == '0))
    else $error("total counters not cleared");

  a_cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> comp_map_r == $past(cfg_complement_map))
    else $error("complement map write lost");

endmodule
